[rtl/esb_pkg.sv]
// ----------------------------------------------------------------------------
// esb_pkg
// Shared types and sizes for the exponential-then-binary search block.
// ----------------------------------------------------------------------------
package esb_pkg;

  localparam int unsigned DEPTH   = 1024;
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // store address
  localparam int unsigned CW      = $clog2(DEPTH + 1);               // element count
  localparam int unsigned IW      = CW + 1;                          // signed probe index
  localparam int unsigned PW      = $clog2(CW + 1);                  // probe exponent
  localparam int unsigned DW      = 32;
  localparam int unsigned POS_W   = 10;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]           kind;
    logic signed [DW-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } result_t;

endpackage

[rtl/exponential_then_binary_search.sv]
// ----------------------------------------------------------------------------
// exponential_then_binary_search
// Sorted store with exponential-then-binary search over one compare unit.
// ----------------------------------------------------------------------------
// Usage: drive item_i and raise start; the item is taken at an edge where
// start is high and busy is low. Append (kind 0) writes item_value at the
// end of the store, dropped when the store holds DEPTH values; clear
// (kind 2) empties it; kind 3 is ignored. These give no result, and busy
// stays low. Search (kind 1) raises busy and walks probes at indices 2^p-1,
// then binary searches the bracket found. Each probe goes through the
// single store read port: an address state, then a compare of the
// registered read data. A probe past the count skips the compare, and so
// does the final check of an empty bracket.
// When done, result_o is shown for exactly one cycle with done_o high, and
// busy drops in that same cycle, so the next item may be taken at once.
// The receiver cannot hold a result off. Reset empties the store (count
// zero), idles the sequencer and clears done_o; store contents are left.
// ----------------------------------------------------------------------------
module exponential_then_binary_search (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  esb_pkg::in_item_t item_i,
  output logic              done_o,
  output esb_pkg::result_t  result_o
);
  import esb_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_EXP     = 5'b00010,
    ST_EXP_CMP = 5'b00100,
    ST_BIN     = 5'b01000,
    ST_BIN_CMP = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [PW-1:0]        p_q, p_d;
  logic signed [IW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic signed [DW-1:0] key_q, key_d;
  logic                 done_q, done_d;
  result_t              result_q, result_d;

  logic                 accept;
  logic                 we;
  logic [AW-1:0]        raddr;
  logic [DW-1:0]        rdata;
  logic [IW-1:0]        exp_idx;
  logic [IW-1:0]        count_ext;
  logic signed [IW-1:0] mid_calc;
  logic signed [IW-1:0] lo_set, hi_set;
  logic                 rd_eq, rd_gt;

  assign accept    = start && (state_q == ST_IDLE);
  assign busy      = (state_q != ST_IDLE);
  assign we        = accept && (kind_e'(item_i.kind) == KIND_APPEND) &&
                     (count_q < CW'(DEPTH));
  assign exp_idx   = (IW'(1) << p_q) - IW'(1);
  assign count_ext = {1'b0, count_q};
  assign mid_calc  = lo_q + ((hi_q - lo_q) >>> 1);
  assign lo_set    = (p_q == '0) ? '0 : $signed(IW'(1) << (p_q - PW'(1)));
  assign hi_set    = $signed(IW'(1) << p_q) - $signed(IW'(2));
  assign rd_eq     = ($signed(rdata) == key_q);
  assign rd_gt     = ($signed(rdata) > key_q);
  assign raddr     = (state_q == ST_EXP) ? exp_idx[AW-1:0] : mid_calc[AW-1:0];

  esb_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (item_i.item_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    p_d      = p_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    key_d    = key_q;
    done_d   = 1'b0;
    result_d = result_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (kind_e'(item_i.kind))
            KIND_APPEND: begin
              if (we) begin
                count_d = count_q + CW'(1);
              end
            end
            KIND_SEARCH: begin
              key_d   = item_i.item_value;
              p_d     = '0;
              state_d = ST_EXP;
            end
            KIND_CLEAR: begin
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_EXP: begin
        // Probe beyond the count ends the doubling phase.
        if (exp_idx >= count_ext) begin
          lo_d    = lo_set;
          hi_d    = hi_set;
          state_d = ST_BIN;
        end else begin
          state_d = ST_EXP_CMP;
        end
      end
      ST_EXP_CMP: begin
        if (rd_eq) begin
          result_d.found    = 1'b1;
          result_d.position = POS_W'(exp_idx);
          done_d            = 1'b1;
          state_d           = ST_IDLE;
        end else if (rd_gt) begin
          lo_d    = lo_set;
          hi_d    = hi_set;
          state_d = ST_BIN;
        end else begin
          p_d     = p_q + PW'(1);
          state_d = ST_EXP;
        end
      end
      ST_BIN: begin
        if (lo_q > hi_q) begin
          result_d.found    = 1'b0;
          result_d.position = '0;
          done_d            = 1'b1;
          state_d           = ST_IDLE;
        end else if ($unsigned(mid_calc) >= count_ext) begin
          // Out-of-range midpoint acts as greater than the key.
          hi_d = mid_calc - $signed(IW'(1));
        end else begin
          mid_d   = mid_calc;
          state_d = ST_BIN_CMP;
        end
      end
      ST_BIN_CMP: begin
        if (rd_eq) begin
          result_d.found    = 1'b1;
          result_d.position = POS_W'($unsigned(mid_q));
          done_d            = 1'b1;
          state_d           = ST_IDLE;
        end else if (rd_gt) begin
          hi_d    = mid_q - $signed(IW'(1));
          state_d = ST_BIN;
        end else begin
          lo_d    = mid_q + $signed(IW'(1));
          state_d = ST_BIN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    key_q    <= key_d;
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

[rtl/esb_ram.sv]
// ----------------------------------------------------------------------------
// esb_ram
// Value store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module esb_ram (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [esb_pkg::AW-1:0] waddr_i,
  input  logic [esb_pkg::DW-1:0] wdata_i,
  input  logic [esb_pkg::AW-1:0] raddr_i,
  output logic [esb_pkg::DW-1:0] rdata_o
);
  import esb_pkg::*;

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/esb_checker.sv]
// ----------------------------------------------------------------------------
// esb_checker
// Port-level checks on the search block's result strobe and busy flag.
// ----------------------------------------------------------------------------
module esb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input esb_pkg::in_item_t item_i,
  input logic              done_o,
  input esb_pkg::result_t  result_o
);
  import esb_pkg::*;

  // A result only ends a search that held busy.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !busy))
    else $error("result strobe without a search in progress");

  // Results never come in consecutive cycles.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // A miss reports position zero.
  a_miss_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.found) |-> (result_o.position == '0))
    else $error("not-found result with nonzero position");

  // A taken search keeps the block busy; append and clear do not.
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.kind == KIND_SEARCH)) |=> busy)
    else $error("search item did not start a search");

  a_other_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.kind != KIND_SEARCH)) |=> (!busy && !done_o))
    else $error("append or clear item left the block busy");

endmodule

bind exponential_then_binary_search esb_checker u_esb_checker (.*);
